### src/pcpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pulsed current phase timer package
// Shared widths, register indexes and phase codes for the phase timer.
// ----------------------------------------------------------------------------
package pcpt_pkg;

  // Sizing of the section tables and the timed values.
  localparam int SECTIONS     = 4;
  localparam int TIME_BITS    = 16;
  localparam int CURRENT_BITS = 16;
  localparam int LANE_BITS    = 16;
  localparam int SEC_BITS     = 2;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;

  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  // Register indexes.
  localparam cfg_idx_t REG_PULSE_DUR = 3'd0;
  localparam cfg_idx_t REG_PEAK_DUR  = 3'd1;
  localparam cfg_idx_t REG_BASE_DUR  = 3'd2;
  localparam cfg_idx_t REG_PULSE_CUR = 3'd3;
  localparam cfg_idx_t REG_PEAK_CUR  = 3'd4;
  localparam cfg_idx_t REG_BASE_CUR  = 3'd5;

  // Phase codes on the result channel.
  typedef logic [1:0] phase_t;
  localparam phase_t PHASE_PEAK  = 2'd0;
  localparam phase_t PHASE_BASE  = 2'd1;
  localparam phase_t PHASE_PULSE = 2'd2;

  typedef logic [SEC_BITS-1:0]     sec_t;
  typedef logic [TIME_BITS-1:0]    ticks_t;
  typedef logic [CURRENT_BITS-1:0] current_t;
  typedef logic [15:0]             setpoint_t;

endpackage : pcpt_pkg
`default_nettype wire

### src/pcpt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Phase timer channel interfaces
// Valid/ready channels for timer ticks in and phase results out.
// ----------------------------------------------------------------------------

// Input channel: one timer tick per transfer.
interface pcpt_in_if
  import pcpt_pkg::*;
();
  logic valid;
  logic ready;
  logic pulse_switch_on;
  logic current_switch_on;
  logic weld_active;
  logic cruise_active;
  sec_t section;

  modport source (output valid, output pulse_switch_on, output current_switch_on,
                  output weld_active, output cruise_active, output section,
                  input ready);
  modport sink   (input valid, input pulse_switch_on, input current_switch_on,
                  input weld_active, input cruise_active, input section,
                  output ready);
endinterface : pcpt_in_if

// Result channel: one phase result per transfer.
interface pcpt_out_if
  import pcpt_pkg::*;
();
  logic      valid;
  logic      ready;
  phase_t    phase;
  logic      pulsing_enabled;
  setpoint_t current_setpoint;

  modport source (output valid, output phase, output pulsing_enabled,
                  output current_setpoint, input ready);
  modport sink   (input valid, input phase, input pulsing_enabled,
                  input current_setpoint, output ready);
endinterface : pcpt_out_if
`default_nettype wire

### src/pulsed_current_phase_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pulsed current phase timer
// Per-tick pulse/peak/base sequencer with per-section current selection.
// ----------------------------------------------------------------------------
// Each input transfer is one timer tick and yields exactly one result. The
// sequencer and the current selection are evaluated in the cycle the tick is
// transferred and land in a result register, so a result appears in the cycle
// after its tick. The block takes one tick per clock cycle: ready is high
// whenever the result register is empty or its result is being transferred
// in the same cycle, so a stalled result only stalls the input. The six
// configuration registers hold four 16-bit lanes each, lane s for section s,
// and should be written while no tick is in flight.
module pulsed_current_phase_timer
  import pcpt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire cfg_idx_t  cfg_index,
  input  wire cfg_data_t cfg_wdata,
  pcpt_in_if.sink        in_ch,
  pcpt_out_if.source     out_ch
);

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PULSE = 2'd1;
  localparam logic [1:0] ST_PEAK  = 2'd2;
  localparam logic [1:0] ST_BASE  = 2'd3;

  // Configuration registers.
  cfg_data_t pulse_dur_r, peak_dur_r, base_dur_r;
  cfg_data_t pulse_cur_r, peak_cur_r, base_cur_r;

  // Sequencer and current state.
  logic [1:0] state_r, state_nxt;
  ticks_t     ticks_r, ticks_nxt;
  logic       cruise_run_r, cruise_run_nxt;
  current_t   hold_r, hold_nxt;

  // Result register.
  logic       out_valid_r;
  phase_t     phase_r, phase_nxt;
  logic       pen_r;

  logic       in_xfer;
  sec_t       sec;
  logic       running;
  ticks_t     dur_pulse, dur_peak, dur_base;
  current_t   cur_pulse, cur_peak, cur_base;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Saturate the section index to the table size.
  always_comb begin
    if (32'(in_ch.section) >= 32'(SECTIONS)) begin
      sec = SEC_BITS'(SECTIONS - 1);
    end else begin
      sec = in_ch.section;
    end
  end

  // Lane selection out of the configuration registers; the low bits of each
  // lane carry the value.
  assign dur_pulse = pulse_dur_r[{sec, 4'b0} +: TIME_BITS];
  assign dur_peak  = peak_dur_r[{sec, 4'b0} +: TIME_BITS];
  assign dur_base  = base_dur_r[{sec, 4'b0} +: TIME_BITS];
  assign cur_pulse = pulse_cur_r[{sec, 4'b0} +: CURRENT_BITS];
  assign cur_peak  = peak_cur_r[{sec, 4'b0} +: CURRENT_BITS];
  assign cur_base  = base_cur_r[{sec, 4'b0} +: CURRENT_BITS];

  assign running = ticks_r > ticks_t'(1);

  // Phase sequencer: a timed state runs while more than one tick is left.
  always_comb begin
    state_nxt = state_r;
    ticks_nxt = ticks_r;
    phase_nxt = PHASE_PEAK;
    if (in_ch.pulse_switch_on && in_ch.weld_active) begin
      case (state_r)
        ST_IDLE: begin
          ticks_nxt = dur_pulse;
          state_nxt = ST_PULSE;
        end
        ST_PULSE: begin
          if (running) begin
            ticks_nxt = ticks_r - ticks_t'(1);
            phase_nxt = PHASE_PULSE;
          end else begin
            ticks_nxt = dur_peak;
            state_nxt = ST_PEAK;
          end
        end
        ST_PEAK: begin
          if (running) begin
            ticks_nxt = ticks_r - ticks_t'(1);
          end else begin
            ticks_nxt = dur_base;
            phase_nxt = PHASE_BASE;
            state_nxt = ST_BASE;
          end
        end
        default: begin
          if (running) begin
            ticks_nxt = ticks_r - ticks_t'(1);
            phase_nxt = PHASE_BASE;
          end else begin
            ticks_nxt = dur_peak;
            state_nxt = ST_IDLE;
          end
        end
      endcase
    end
  end

  // Cruise current selection from the freshly updated phase.
  always_comb begin
    cruise_run_nxt = cruise_run_r;
    hold_nxt       = hold_r;
    if (in_ch.cruise_active) begin
      if (!cruise_run_r) begin
        if (in_ch.current_switch_on) begin
          cruise_run_nxt = 1'b1;
        end
      end else begin
        case (phase_nxt)
          PHASE_PEAK:  hold_nxt = cur_peak;
          PHASE_BASE:  hold_nxt = cur_base;
          PHASE_PULSE: hold_nxt = cur_pulse;
          default:     hold_nxt = hold_r;
        endcase
      end
    end
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_dur_r <= '0;
      peak_dur_r  <= '0;
      base_dur_r  <= '0;
      pulse_cur_r <= '0;
      peak_cur_r  <= '0;
      base_cur_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_DUR: pulse_dur_r <= cfg_wdata;
        REG_PEAK_DUR:  peak_dur_r  <= cfg_wdata;
        REG_BASE_DUR:  base_dur_r  <= cfg_wdata;
        REG_PULSE_CUR: pulse_cur_r <= cfg_wdata;
        REG_PEAK_CUR:  peak_cur_r  <= cfg_wdata;
        REG_BASE_CUR:  base_cur_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State update on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ticks_r      <= '0;
      cruise_run_r <= 1'b0;
      hold_r       <= '0;
    end else if (in_xfer) begin
      state_r      <= state_nxt;
      ticks_r      <= ticks_nxt;
      cruise_run_r <= cruise_run_nxt;
      hold_r       <= hold_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; the held current is read straight from its register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      phase_r <= phase_nxt;
      pen_r   <= in_ch.pulse_switch_on;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.phase            = phase_r;
  assign out_ch.pulsing_enabled  = pen_r;
  assign out_ch.current_setpoint = setpoint_t'(hold_r);

endmodule : pulsed_current_phase_timer
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulsed current phase timer testbench
// Drives timer ticks with random gaps and back-pressure, predicts every
// phase result in a scoreboard class and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pcpt_pkg::*;

  localparam int NUM_REGS       = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_SLACK    = 3;
  localparam int PHASE_COUNT    = 6;
  localparam int PHASE_ITEMS    = 64;
  localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(NUM_REGS);

  typedef enum logic [1:0] {TMR_IDLE, TMR_PULSE, TMR_PEAK, TMR_BASE} timer_state_t;

  typedef struct packed {
    logic pulse_switch_on;
    logic current_switch_on;
    logic weld_active;
    logic cruise_active;
    sec_t section;
  } tick_t;

  typedef struct packed {
    phase_t    phase;
    logic      pulsing_enabled;
    setpoint_t current_setpoint;
  } phase_result_t;

  typedef cfg_data_t reg_set_t [NUM_REGS];

  // Tracks the sequencer and current selection, and holds the results that
  // the block still owes.
  class phase_timer_scoreboard;
    cfg_data_t     regs [NUM_REGS];
    timer_state_t  state;
    ticks_t        ticks_left;
    phase_t        phase_code;
    bit            cruise_running;
    setpoint_t     current_hold;
    phase_result_t owed_results [$];
    int            errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      state          = TMR_IDLE;
      ticks_left     = '0;
      phase_code     = PHASE_PEAK;
      cruise_running = 1'b0;
      current_hold   = '0;
      errors         = 0;
    endfunction

    // Writes to an index beyond the register list are dropped.
    function void set_reg(cfg_idx_t idx, cfg_data_t val);
      if (idx < NUM_REGS) regs[idx] = val;
    endfunction

    function logic [LANE_BITS-1:0] lane(cfg_idx_t idx, sec_t s);
      return regs[idx][LANE_BITS*s +: LANE_BITS];
    endfunction

    // True while the timed state still runs; takes one tick off.
    function bit count_down();
      if (ticks_left > 1) begin
        ticks_left--;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void note_tick(tick_t t);
      sec_t          s;
      phase_result_t r;
      s = (t.section >= SECTIONS) ? sec_t'(SECTIONS - 1) : t.section;

      // The sequencer only advances while pulsing is on and welding runs.
      if (!t.pulse_switch_on || !t.weld_active) begin
        phase_code = PHASE_PEAK;
      end else begin
        case (state)
          TMR_IDLE: begin
            phase_code = PHASE_PEAK;
            ticks_left = ticks_t'(lane(REG_PULSE_DUR, s));
            state      = TMR_PULSE;
          end
          TMR_PULSE: begin
            if (count_down()) begin
              phase_code = PHASE_PULSE;
            end else begin
              ticks_left = ticks_t'(lane(REG_PEAK_DUR, s));
              phase_code = PHASE_PEAK;
              state      = TMR_PEAK;
            end
          end
          TMR_PEAK: begin
            if (count_down()) begin
              phase_code = PHASE_PEAK;
            end else begin
              ticks_left = ticks_t'(lane(REG_BASE_DUR, s));
              phase_code = PHASE_BASE;
              state      = TMR_BASE;
            end
          end
          default: begin
            if (count_down()) begin
              phase_code = PHASE_BASE;
            end else begin
              ticks_left = ticks_t'(lane(REG_PEAK_DUR, s));
              phase_code = PHASE_PEAK;
              state      = TMR_IDLE;
            end
          end
        endcase
      end

      // Cruise latches on the first enabled tick, then follows the phase.
      if (t.cruise_active) begin
        if (!cruise_running) begin
          if (t.current_switch_on) cruise_running = 1'b1;
        end else begin
          case (phase_code)
            PHASE_PEAK:  current_hold = setpoint_t'(lane(REG_PEAK_CUR, s));
            PHASE_BASE:  current_hold = setpoint_t'(lane(REG_BASE_CUR, s));
            PHASE_PULSE: current_hold = setpoint_t'(lane(REG_PULSE_CUR, s));
            default: ;
          endcase
        end
      end

      r.phase            = phase_code;
      r.pulsing_enabled  = t.pulse_switch_on;
      r.current_setpoint = current_hold;
      owed_results.push_back(r);
    endfunction

    function void check_result(phase_result_t r);
      phase_result_t e;
      if (owed_results.size() == 0) begin
        $error("result transfer with no tick outstanding");
        errors++;
        return;
      end
      e = owed_results.pop_front();
      if (r.phase !== e.phase) begin
        $error("phase: expected %0d, got %0d", e.phase, r.phase);
        errors++;
      end
      if (r.pulsing_enabled !== e.pulsing_enabled) begin
        $error("pulsing_enabled: expected %0b, got %0b", e.pulsing_enabled,
               r.pulsing_enabled);
        errors++;
      end
      if (r.current_setpoint !== e.current_setpoint) begin
        $error("current_setpoint: expected 0x%04h, got 0x%04h", e.current_setpoint,
               r.current_setpoint);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;
  int        idle_max;
  int        idle_cycles;

  pcpt_in_if  in_ch ();
  pcpt_out_if out_ch ();

  phase_timer_scoreboard model = new();

  pulsed_current_phase_timer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Free-running 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Every transfer on both channels goes to the scoreboard; the watchdog
  // ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        model.note_tick({in_ch.pulse_switch_on, in_ch.current_switch_on,
                         in_ch.weld_active, in_ch.cruise_active, in_ch.section});
      end
      if (out_ch.valid && out_ch.ready) begin
        model.check_result({out_ch.phase, out_ch.pulsing_enabled,
                            out_ch.current_setpoint});
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side: a random stall before each transfer.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, idle_max);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  function automatic tick_t mk_tick(bit pen, bit cen, bit weld, bit cruise, int s);
    tick_t t;
    t.pulse_switch_on   = pen;
    t.current_switch_on = cen;
    t.weld_active       = weld;
    t.cruise_active     = cruise;
    t.section           = sec_t'(s);
    return t;
  endfunction

  // Mostly ticks that keep the sequencer running, with some that stop it.
  function automatic tick_t random_tick();
    tick_t t;
    t = tick_t'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      t.pulse_switch_on = 1'b1;
      t.weld_active     = 1'b1;
      t.cruise_active   = ($urandom_range(0, 3) != 0);
    end
    return t;
  endfunction

  // Short durations so that the sequencer goes round often.
  function automatic reg_set_t random_set();
    reg_set_t v;
    for (int s = 0; s < SECTIONS; s++) begin
      v[REG_PULSE_DUR][LANE_BITS*s +: LANE_BITS] = LANE_BITS'($urandom_range(0, 6));
      v[REG_PEAK_DUR][LANE_BITS*s +: LANE_BITS]  = LANE_BITS'($urandom_range(0, 6));
      v[REG_BASE_DUR][LANE_BITS*s +: LANE_BITS]  = LANE_BITS'($urandom_range(0, 6));
      v[REG_PULSE_CUR][LANE_BITS*s +: LANE_BITS] = LANE_BITS'($urandom);
      v[REG_PEAK_CUR][LANE_BITS*s +: LANE_BITS]  = LANE_BITS'($urandom);
      v[REG_BASE_CUR][LANE_BITS*s +: LANE_BITS]  = LANE_BITS'($urandom);
    end
    return v;
  endfunction

  // One tick transfer after a random gap.
  task automatic send_tick(tick_t t);
    int gap;
    gap = $urandom_range(0, idle_max);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid             <= 1'b1;
    in_ch.pulse_switch_on   <= t.pulse_switch_on;
    in_ch.current_switch_on <= t.current_switch_on;
    in_ch.weld_active       <= t.weld_active;
    in_ch.cruise_active     <= t.cruise_active;
    in_ch.section           <= t.section;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Stops the ticks and waits until every owed result has come out.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic load_config(reg_set_t vals, bit poke_unused);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      model.set_reg(cfg_idx_t'(i), vals[i]);
    end
    // A write past the register list must leave every register alone.
    if (poke_unused) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= REG_UNUSED;
      cfg_wdata <= {$urandom, $urandom};
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main sequence: reset, directed ticks, then random phases.
  initial begin
    reg_set_t cfg_set;
    in_ch.valid             = 1'b0;
    in_ch.pulse_switch_on   = 1'b0;
    in_ch.current_switch_on = 1'b0;
    in_ch.weld_active       = 1'b0;
    in_ch.cruise_active     = 1'b0;
    in_ch.section           = '0;
    cfg_we                  = 1'b0;
    cfg_index               = REG_PULSE_DUR;
    cfg_wdata               = '0;
    idle_max                = 0;
    idle_cycles             = 0;
    rst_n                   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset tables: cruise must not start without the current switch or
    // outside cruise, then starts on the first enabled cruise tick.
    send_tick(mk_tick(0, 0, 1, 1, 0));
    send_tick(mk_tick(1, 1, 0, 0, 1));
    send_tick(mk_tick(1, 1, 1, 1, 2));
    send_tick(mk_tick(1, 0, 1, 1, 3));
    drain_results();

    // Distinct lanes per section, zero and one tick durations among them.
    cfg_set[REG_PULSE_DUR] = {16'd3, 16'd1, 16'd0, 16'd2};
    cfg_set[REG_PEAK_DUR]  = {16'd0, 16'd2, 16'd1, 16'd3};
    cfg_set[REG_BASE_DUR]  = {16'd2, 16'd0, 16'd1, 16'd2};
    cfg_set[REG_PULSE_CUR] = {16'hFFFF, 16'h0A02, 16'h0A01, 16'h0A00};
    cfg_set[REG_PEAK_CUR]  = {16'h0B03, 16'h0000, 16'h0B01, 16'h0B00};
    cfg_set[REG_BASE_CUR]  = {16'h0C03, 16'h0C02, 16'h0C01, 16'h0C00};
    load_config(cfg_set, 1'b1);

    // One full pulse, peak and base round, then the hold cases, then every
    // section in turn.
    repeat (7) send_tick(mk_tick(1, 0, 1, 1, 0));
    send_tick(mk_tick(1, 1, 0, 1, 0));
    send_tick(mk_tick(0, 1, 1, 1, 0));
    send_tick(mk_tick(1, 0, 1, 0, 1));
    for (int s = 1; s < SECTIONS; s++) begin
      repeat (4) send_tick(mk_tick(1, 1'(s % 2), 1, 1, s));
    end
    drain_results();

    // Random phases; all-zero tables early and all-ones tables last, since
    // the longest durations hold the sequencer for the rest of the run.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph == 1) begin
        cfg_set = '{default: '0};
      end else if (ph == PHASE_COUNT - 1) begin
        cfg_set = '{default: '1};
      end else begin
        cfg_set = random_set();
      end
      load_config(cfg_set, ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        idle_max = (ph == 0 || (n % 32) < 8) ? 0 : 3;
        if (ph == 2 && n == 32) drain_results();
        send_tick(random_tick());
      end
      drain_results();
    end

    if (model.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : testbench
